@@ src/srl_pkg.sv @@
// Shared types and constants for the sorted ring list unit.
// No dependencies; used by the top level and the checker.
package srl_pkg;

    // default configuration
    localparam int DEPTH_DEFAULT     = 16;
    localparam int KEY_WIDTH_DEFAULT = 32;

    // fixed field widths of the transaction payloads
    localparam int KEY_FIELD_W   = 32;
    localparam int HEAD_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MEMBER = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // input transaction
    typedef struct packed {
        op_t                            op;
        logic signed [KEY_FIELD_W-1:0]  key;
    } in_item_t;

    // result transaction
    typedef struct packed {
        status_t                    status;
        logic [HEAD_FIELD_W-1:0]    head_position;
        logic [COUNT_FIELD_W-1:0]   entry_count;
    } out_item_t;

endpackage

@@ src/srl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module srl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/sorted_ring_list_unit.sv @@
// Sorted ring list unit: top level with the operation sequencer.
// Depends on srl_pkg and srl_ram.
//
// Keeps signed keys in ascending order in a DEPTH-entry circular buffer held in
// one RAM with a single write and a single registered read port. Every input
// transaction (insert, remove key, membership test, pop head) returns exactly
// one result with status, head index and count. A pop, an insert into a full
// list or a remove from an empty list goes from the accept straight to the
// result. Insert, remove and membership first scan the stored keys from the
// head, one RAM read a cycle, pipelined against the compare. Insert and middle
// removal then move the later entries one slot, one read and one write a
// cycle, and wait for the last write to drain. A scan that stops early leaves
// more entries to move. Insert and middle removal end in a final update state
// before the result. A new transaction is taken once the previous result sits
// in the output register, even if it waits there.
module sorted_ring_list_unit #(
    parameter int DEPTH     = srl_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = srl_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srl_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output srl_pkg::out_item_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_FINAL  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    srl_pkg::op_t               op_reg, op_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    srl_pkg::status_t           status_reg, status_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              rd_idx_reg, rd_idx_next;
    logic [CW-1:0]              dst_reg, dst_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic                       wr_valid_reg, wr_valid_next;
    logic [AW-1:0]              wr_addr_reg, wr_addr_next;
    logic                       m_valid_reg, m_valid_next;
    srl_pkg::out_item_t         m_data_reg, m_data_next;

    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [KEY_WIDTH-1:0]       ram_wr_data;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [KEY_WIDTH-1:0]       ram_rd_data;

    logic signed [KEY_WIDTH-1:0] rd_key;
    logic                       hit;
    logic                       srch_end;
    logic                       srch_found;
    logic [CW-1:0]              srch_pos;
    logic [CW-1:0]              dst_inc;
    logic [AW-1:0]              head_inc;
    logic [AW-1:0]              tail_inc;
    logic [AW-1:0]              tail_dec;

    // physical index of a logical position counted from the head
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offs);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // key storage
    srl_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // pointer steps with wrap
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);
    assign dst_inc  = dst_reg + CW'(1);

    // compare of the key read in the previous cycle
    assign rd_key = $signed(ram_rd_data);
    assign hit    = rd_valid_reg && ((op_reg == srl_pkg::OP_INSERT) ? (rd_key > key_reg)
                                                                    : (rd_key == key_reg));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        rd_idx_next   = rd_idx_reg;
        dst_next      = dst_reg;
        wr_addr_next  = wr_addr_reg;
        m_data_next   = m_data_reg;
        rd_valid_next = 1'b0;
        wr_valid_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        ram_wr_en     = wr_valid_reg;
        ram_wr_addr   = wr_addr_reg;
        ram_wr_data   = ram_rd_data;
        srch_end      = 1'b0;
        srch_found    = 1'b0;
        srch_pos      = count_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.op;
                    key_next   = KEY_WIDTH'(s_data.key);
                    idx_next   = '0;
                    state_next = S_SEARCH;
                    case (s_data.op)
                        srl_pkg::OP_INSERT: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = srl_pkg::STAT_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        srl_pkg::OP_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = srl_pkg::STAT_EMPTY;
                                state_next  = S_DONE;
                            end
                        end
                        srl_pkg::OP_POP: begin
                            state_next = S_DONE;
                            if (count_reg == '0) begin
                                status_next = srl_pkg::STAT_EMPTY;
                            end else begin
                                status_next = srl_pkg::STAT_OK;
                                head_next   = head_inc;
                                count_next  = count_reg - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // one read issued per cycle, compared in the next cycle
                if (hit) begin
                    srch_end   = 1'b1;
                    srch_found = 1'b1;
                    srch_pos   = rd_idx_reg;
                end else if (idx_reg < count_reg) begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = ring_addr(head_reg, idx_reg);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end else if (!rd_valid_reg) begin
                    srch_end = 1'b1;
                end

                if (srch_end) begin
                    case (op_reg)
                        srl_pkg::OP_INSERT: begin
                            pos_next   = srch_pos;
                            dst_next   = count_reg;
                            state_next = S_SHIFT;
                        end
                        srl_pkg::OP_REMOVE: begin
                            if (!srch_found) begin
                                status_next = srl_pkg::STAT_NOTFOUND;
                                state_next  = S_DONE;
                            end else if (srch_pos == '0) begin
                                status_next = srl_pkg::STAT_OK;
                                head_next   = head_inc;
                                count_next  = count_reg - CW'(1);
                                state_next  = S_DONE;
                            end else begin
                                pos_next   = srch_pos;
                                dst_next   = srch_pos;
                                state_next = S_SHIFT;
                            end
                        end
                        default: begin
                            status_next = srch_found ? srl_pkg::STAT_OK
                                                     : srl_pkg::STAT_NOTFOUND;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // read one slot, write it to its neighbor in the next cycle
                if (op_reg == srl_pkg::OP_INSERT) begin
                    if (dst_reg > pos_reg) begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = ring_addr(head_reg, dst_reg - CW'(1));
                        wr_valid_next = 1'b1;
                        wr_addr_next  = ring_addr(head_reg, dst_reg);
                        dst_next      = dst_reg - CW'(1);
                    end else if (!wr_valid_reg) begin
                        state_next = S_FINAL;
                    end
                end else begin
                    if (dst_inc < count_reg) begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = ring_addr(head_reg, dst_inc);
                        wr_valid_next = 1'b1;
                        wr_addr_next  = ring_addr(head_reg, dst_reg);
                        dst_next      = dst_inc;
                    end else if (!wr_valid_reg) begin
                        state_next = S_FINAL;
                    end
                end
            end

            S_FINAL: begin
                status_next = srl_pkg::STAT_OK;
                state_next  = S_DONE;
                if (op_reg == srl_pkg::OP_INSERT) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ring_addr(head_reg, pos_reg);
                    ram_wr_data = key_reg;
                    tail_next   = tail_inc;
                    count_next  = count_reg + CW'(1);
                end else begin
                    tail_next  = tail_dec;
                    count_next = count_reg - CW'(1);
                end
            end

            S_DONE: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status        = status_reg;
                    m_data_next.head_position = (srl_pkg::HEAD_FIELD_W)'(head_reg);
                    m_data_next.entry_count   = (srl_pkg::COUNT_FIELD_W)'(count_reg);
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            wr_valid_reg <= wr_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= rd_idx_next;
        dst_reg     <= dst_next;
        wr_addr_reg <= wr_addr_next;
        m_data_reg  <= m_data_next;
    end

endmodule

@@ src/srl_checker.sv @@
// Port-level checker for the sorted ring list unit, bound to the top level.
// Depends on srl_pkg and sorted_ring_list_unit.
module srl_checker #(
    parameter int DEPTH = srl_pkg::DEPTH_DEFAULT
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input srl_pkg::out_item_t m_data
);

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // one transaction at a time: input closes right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after accept");

    // full status only with a full list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == srl_pkg::STAT_FULL))
            |-> ((DEPTH > 31) || (m_data.entry_count == 5'(DEPTH))))
        else $error("full status with spare room");

    // empty status only with an empty list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == srl_pkg::STAT_EMPTY)) |-> (m_data.entry_count == '0))
        else $error("empty status with stored keys");

    // count never exceeds the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((DEPTH > 31) || (m_data.entry_count <= 5'(DEPTH))))
        else $error("count beyond capacity");

endmodule

bind sorted_ring_list_unit srl_checker #(
    .DEPTH (DEPTH)
) u_srl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
